// ===== sv/dgp_pkg.sv =====
// shared types, constants and helpers for the go-to-point controller
package dgp_pkg;

   localparam int CORDIC_STAGES_DEFAULT = 14;
   localparam int ATAN_ENTRIES          = 20;

   // datapath widths of the two cordic pipelines
   localparam int VEC_W = 28;
   localparam int ROT_W = 33;

   // arctangent table, a full turn is 2^32
   localparam logic [31:0] ATAN_TAB [ATAN_ENTRIES] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
      32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518
   };

   localparam logic signed [ROT_W-1:0] INV_GAIN_Q30 = 33'sd652032875;

   // register indexes on the csr port
   localparam int CSR_IDX_W = 4;
   localparam logic [CSR_IDX_W-1:0] CSR_ANGLE_TOLERANCE = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEADING_GAIN    = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED_GAIN      = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TURN_LIMIT      = 4'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED_LIMIT     = 4'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_ARRIVE_RADIUS   = 4'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_ROBOT_RADIUS    = 4'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPIN_GAIN       = 4'd7;
   localparam int CSR_DATA_W = 16;

   // register reset values
   localparam logic [13:0] RST_ANGLE_TOLERANCE = 14'd910;
   localparam logic [15:0] RST_HEADING_GAIN    = 16'd4915;
   localparam logic [15:0] RST_SPEED_GAIN      = 16'd4096;
   localparam logic [14:0] RST_TURN_LIMIT      = 15'd3277;
   localparam logic [14:0] RST_SPEED_LIMIT     = 15'd2294;
   localparam logic [14:0] RST_ARRIVE_RADIUS   = 15'd287;
   localparam logic [12:0] RST_ROBOT_RADIUS    = 13'd0;
   localparam logic [15:0] RST_SPIN_GAIN       = 16'd1229;

   typedef enum logic [1:0] {
      MODE_SPIN   = 2'd0,
      MODE_DRIVE  = 2'd1,
      MODE_ARRIVE = 2'd2
   } mode_type;

   typedef struct packed {
      logic signed [15:0] goal_x;
      logic signed [15:0] goal_y;
      logic signed [15:0] pose_x;
      logic signed [15:0] pose_y;
      logic signed [15:0] pose_heading;
   } req_type;

   typedef struct packed {
      logic signed [15:0] left_speed;
      logic signed [15:0] right_speed;
      mode_type           mode;
   } rsp_type;

   // saturate a 19 bit signed value to 16 bits
   function automatic logic signed [15:0] sat16(input logic signed [18:0] v);
      logic signed [15:0] r;
      if (v > 19'sd32767) begin
         r = 16'sh7FFF;
      end else if (v < -19'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

endpackage

// ===== sv/diff_drive_go_to_point_unit.sv =====
// top level of the differential drive go-to-point controller
//
// usage: each transfer on the req_ channel carries a goal point and the robot
// pose; each produces exactly one transfer on the rsp_ channel with the left
// and right wheel speeds and the mode (spin, drive or arrived), in order.
// registers are written on the csr_ port (write enable, index, data) and
// must only change while no pose is in flight; unknown indexes are ignored.
// from the req_ transfer to rsp_valid a pose passes the input register, the
// vectoring cordic, the cosine cordic and the multiplier stages around them.
// throughput: one pose per cycle unless stalled; every stage holds one pose.
// reset clears all valid bits and loads the register defaults.
// when rsp_stall holds a waiting result the whole pipeline freezes and
// req_stall rises; nothing is lost or repeated, and bubbles keep moving
// while the output register is empty.
module diff_drive_go_to_point_unit #(
   parameter int CORDIC_STAGES = dgp_pkg::CORDIC_STAGES_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  dgp_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output dgp_pkg::rsp_type                  rsp_data,
   input  logic                              csr_we,
   input  logic [dgp_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [dgp_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import dgp_pkg::*;

   localparam int ROT_SIDE_W = 66 + 66 + 36 + 19 + 1 + 1;

   // configuration registers
   logic [13:0] tol_ff;
   logic [15:0] hgain_ff, sgain_ff, spgain_ff;
   logic [14:0] tlim_ff, vlim_ff, arad_ff;
   logic [12:0] rrad_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff    <= RST_ANGLE_TOLERANCE;
         hgain_ff  <= RST_HEADING_GAIN;
         sgain_ff  <= RST_SPEED_GAIN;
         tlim_ff   <= RST_TURN_LIMIT;
         vlim_ff   <= RST_SPEED_LIMIT;
         arad_ff   <= RST_ARRIVE_RADIUS;
         rrad_ff   <= RST_ROBOT_RADIUS;
         spgain_ff <= RST_SPIN_GAIN;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ANGLE_TOLERANCE: tol_ff    <= csr_wdata[13:0];
            CSR_HEADING_GAIN:    hgain_ff  <= csr_wdata;
            CSR_SPEED_GAIN:      sgain_ff  <= csr_wdata;
            CSR_TURN_LIMIT:      tlim_ff   <= csr_wdata[14:0];
            CSR_SPEED_LIMIT:     vlim_ff   <= csr_wdata[14:0];
            CSR_ARRIVE_RADIUS:   arad_ff   <= csr_wdata[14:0];
            CSR_ROBOT_RADIUS:    rrad_ff   <= csr_wdata[12:0];
            CSR_SPIN_GAIN:       spgain_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // global advance: the pipeline moves unless a finished result is held
   logic en;
   assign en        = !rsp_valid || !rsp_stall;
   assign req_stall = !en;

   // ---------------------------------------------------------------
   // s0: goal minus pose, scaled by 256, folded into the right half plane
   // ---------------------------------------------------------------
   logic signed [16:0]      dx, dy;
   logic signed [VEC_W-1:0] x0_in, y0_in;
   logic [31:0]             a0_in;
   logic                    s0_v_ff;
   logic signed [VEC_W-1:0] s0_x_ff, s0_y_ff;
   logic [31:0]             s0_a_ff;
   logic signed [15:0]      s0_head_ff;

   always_comb begin
      dx = {req_data.goal_x[15], req_data.goal_x} - {req_data.pose_x[15], req_data.pose_x};
      dy = {req_data.goal_y[15], req_data.goal_y} - {req_data.pose_y[15], req_data.pose_y};
      x0_in = {{(VEC_W-25){dx[16]}}, dx, 8'b0};
      y0_in = {{(VEC_W-25){dy[16]}}, dy, 8'b0};
      a0_in = '0;
      if (dx[16]) begin
         x0_in = -x0_in;
         y0_in = -y0_in;
         a0_in = 32'h80000000;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_v_ff <= 1'b0;
      end else if (en) begin
         s0_v_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s0_x_ff    <= x0_in;
         s0_y_ff    <= y0_in;
         s0_a_ff    <= a0_in;
         s0_head_ff <= req_data.pose_heading;
      end
   end

   // vectoring cordic: magnitude and bearing
   logic                    vc_v;
   logic signed [VEC_W-1:0] vc_x;
   logic [31:0]             vc_a;
   logic [15:0]             vc_head;

   dgp_vec_cordic #(
      .STAGES (CORDIC_STAGES),
      .SIDE_W (16)
   ) u_vec (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s0_v_ff),
      .in_x      (s0_x_ff),
      .in_y      (s0_y_ff),
      .in_ang    (s0_a_ff),
      .in_side   (s0_head_ff),
      .out_valid (vc_v),
      .out_x     (vc_x),
      .out_ang   (vc_a),
      .out_side  (vc_head)
   );

   // ---------------------------------------------------------------
   // s1: gain correction product and heading error
   // ---------------------------------------------------------------
   logic [31:0]        bear_rnd;
   logic signed [15:0] err_in;
   logic               s1_v_ff;
   logic signed [44:0] s1_dmul_ff;
   logic signed [15:0] s1_err_ff;

   assign bear_rnd = vc_a + 32'h00008000;
   assign err_in   = $signed(bear_rnd[31:16] - vc_head);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (en) begin
         s1_v_ff <= vc_v;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_dmul_ff <= $signed({{(45-VEC_W){vc_x[VEC_W-1]}}, vc_x}) * 45'sd39797;
         s1_err_ff  <= err_in;
      end
   end

   // ---------------------------------------------------------------
   // s2: distance, spin decision, gain products
   // ---------------------------------------------------------------
   logic signed [44:0] dsum;
   logic signed [18:0] d_in;
   logic signed [32:0] err33;
   logic [16:0]        mag;
   logic               spin_in;
   logic               s2_v_ff, s2_spin_ff;
   logic signed [18:0] s2_d_ff;
   logic signed [15:0] s2_err_ff;
   logic signed [32:0] s2_psp_ff, s2_phd_ff;
   logic signed [35:0] s2_sgd_ff;

   always_comb begin
      dsum    = s1_dmul_ff + (45'sd1 <<< 23);
      d_in    = dsum[42:24];
      err33   = {{17{s1_err_ff[15]}}, s1_err_ff};
      mag     = s1_err_ff[15] ? 17'(-err33) : 17'(err33);
      spin_in = {mag, 1'b0} > (18'(tol_ff) * 18'd3);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else if (en) begin
         s2_v_ff <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_d_ff    <= d_in;
         s2_err_ff  <= s1_err_ff;
         s2_spin_ff <= spin_in;
         s2_psp_ff  <= $signed({17'b0, spgain_ff}) * err33;
         s2_phd_ff  <= $signed({17'b0, hgain_ff}) * err33;
         s2_sgd_ff  <= $signed({20'b0, sgain_ff}) * $signed({{17{d_in[18]}}, d_in});
      end
   end

   // ---------------------------------------------------------------
   // s3: angle scaling by pi, cosine angle folded into +-pi/2
   // ---------------------------------------------------------------
   logic signed [ROT_W-1:0] z_in;
   logic                    neg_in;
   logic                    s3_v_ff, s3_spin_ff, s3_neg_ff;
   logic signed [65:0]      s3_tsp_ff, s3_thd_ff;
   logic signed [ROT_W-1:0] s3_z_ff;
   logic signed [18:0]      s3_d_ff;
   logic signed [35:0]      s3_sgd_ff;

   always_comb begin
      z_in   = {s2_err_ff[15], s2_err_ff, 16'b0};
      neg_in = 1'b0;
      if (z_in > (33'sd1 <<< 30)) begin
         z_in   = z_in - (33'sd1 <<< 31);
         neg_in = 1'b1;
      end else if (z_in < -(33'sd1 <<< 30)) begin
         z_in   = z_in + (33'sd1 <<< 31);
         neg_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_v_ff <= 1'b0;
      end else if (en) begin
         s3_v_ff <= s2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s3_tsp_ff  <= $signed({{33{s2_psp_ff[32]}}, s2_psp_ff}) * 66'sd1686629713;
         s3_thd_ff  <= $signed({{33{s2_phd_ff[32]}}, s2_phd_ff}) * 66'sd1686629713;
         s3_z_ff    <= z_in;
         s3_neg_ff  <= neg_in;
         s3_d_ff    <= s2_d_ff;
         s3_sgd_ff  <= s2_sgd_ff;
         s3_spin_ff <= s2_spin_ff;
      end
   end

   // rotation cordic: cosine of the heading error
   logic                    rc_v;
   logic signed [ROT_W-1:0] rc_x;
   logic [ROT_SIDE_W-1:0]   rc_side;
   logic signed [65:0]      rc_tsp, rc_thd;
   logic signed [35:0]      rc_sgd;
   logic signed [18:0]      rc_d;
   logic                    rc_spin, rc_neg;

   dgp_rot_cordic #(
      .STAGES (CORDIC_STAGES),
      .SIDE_W (ROT_SIDE_W)
   ) u_rot (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s3_v_ff),
      .in_z      (s3_z_ff),
      .in_side   ({s3_tsp_ff, s3_thd_ff, s3_sgd_ff, s3_d_ff, s3_spin_ff, s3_neg_ff}),
      .out_valid (rc_v),
      .out_x     (rc_x),
      .out_side  (rc_side)
   );

   assign {rc_tsp, rc_thd, rc_sgd, rc_d, rc_spin, rc_neg} = rc_side;

   // ---------------------------------------------------------------
   // s4: round the angle products, clamp turn rates, speed product
   // ---------------------------------------------------------------
   logic signed [65:0]      gsp, ghd;
   logic signed [21:0]      tsp, thd, tlim22;
   logic signed [11:0]      turn_in;
   logic signed [15:0]      w_in;
   logic signed [ROT_W-1:0] cosv;
   logic                    s4_v_ff, s4_spin_ff;
   logic signed [11:0]      s4_turn_ff;
   logic signed [15:0]      s4_w_ff;
   logic signed [68:0]      s4_vprod_ff;
   logic signed [18:0]      s4_d_ff;

   always_comb begin
      gsp    = rc_tsp + (66'sd1 <<< 43);
      ghd    = rc_thd + (66'sd1 <<< 43);
      tsp    = gsp[65:44];
      thd    = ghd[65:44];
      tlim22 = $signed({7'b0, tlim_ff});
      if (tsp > 22'sd1229) begin
         turn_in = 12'sd1229;
      end else if (tsp < -22'sd1229) begin
         turn_in = -12'sd1229;
      end else begin
         turn_in = tsp[11:0];
      end
      if (thd > tlim22) begin
         w_in = tlim22[15:0];
      end else if (thd < -tlim22) begin
         w_in = 16'(-tlim22);
      end else begin
         w_in = thd[15:0];
      end
      cosv = rc_neg ? -rc_x : rc_x;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_v_ff <= 1'b0;
      end else if (en) begin
         s4_v_ff <= rc_v;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s4_turn_ff  <= turn_in;
         s4_w_ff     <= w_in;
         s4_vprod_ff <= $signed({{33{rc_sgd[35]}}, rc_sgd})
                      * $signed({{36{cosv[ROT_W-1]}}, cosv});
         s4_d_ff     <= rc_d;
         s4_spin_ff  <= rc_spin;
      end
   end

   // ---------------------------------------------------------------
   // s5: linear speed clamp and wheel offset
   // ---------------------------------------------------------------
   logic signed [68:0] vsum;
   logic signed [26:0] vr, vlim27;
   logic signed [15:0] v_in;
   logic signed [29:0] aprod;
   logic signed [29:0] asum;
   logic               s5_v_ff, s5_spin_ff;
   logic signed [15:0] s5_vel_ff;
   logic signed [17:0] s5_a_ff;
   logic signed [11:0] s5_turn_ff;
   logic signed [18:0] s5_d_ff;

   always_comb begin
      vsum   = s4_vprod_ff + (69'sd1 <<< 41);
      vr     = vsum[68:42];
      vlim27 = $signed({12'b0, vlim_ff});
      if (vr > vlim27) begin
         v_in = vlim27[15:0];
      end else if (vr < -vlim27) begin
         v_in = 16'(-vlim27);
      end else begin
         v_in = vr[15:0];
      end
      aprod = $signed({17'b0, rrad_ff}) * $signed({{14{s4_w_ff[15]}}, s4_w_ff});
      asum  = aprod + 30'sd2048;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_v_ff <= 1'b0;
      end else if (en) begin
         s5_v_ff <= s4_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s5_vel_ff  <= v_in;
         s5_a_ff    <= asum[29:12];
         s5_turn_ff <= s4_turn_ff;
         s5_d_ff    <= s4_d_ff;
         s5_spin_ff <= s4_spin_ff;
      end
   end

   // ---------------------------------------------------------------
   // s6: wheel mix, mode select, output register
   // ---------------------------------------------------------------
   logic signed [18:0] vext, aext;
   rsp_type            rsp_in;
   logic               out_v_ff;
   rsp_type            out_ff;

   always_comb begin
      vext = {{3{s5_vel_ff[15]}}, s5_vel_ff};
      aext = {s5_a_ff[17], s5_a_ff};
      if (s5_spin_ff) begin
         rsp_in.right_speed = {{4{s5_turn_ff[11]}}, s5_turn_ff};
         rsp_in.left_speed  = 16'(-$signed({{4{s5_turn_ff[11]}}, s5_turn_ff}));
         rsp_in.mode        = MODE_SPIN;
      end else if (s5_d_ff > $signed({4'b0, arad_ff})) begin
         rsp_in.left_speed  = sat16(vext - aext);
         rsp_in.right_speed = sat16(vext + aext);
         rsp_in.mode        = MODE_DRIVE;
      end else begin
         rsp_in.left_speed  = '0;
         rsp_in.right_speed = '0;
         rsp_in.mode        = MODE_ARRIVE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (en) begin
         out_v_ff <= s5_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_ff <= rsp_in;
      end
   end

   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;

endmodule

// ===== sv/dgp_vec_cordic.sv =====
// vectoring cordic pipeline, one stage per iteration, with sideband
module dgp_vec_cordic #(
   parameter int STAGES = dgp_pkg::CORDIC_STAGES_DEFAULT,
   parameter int SIDE_W = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               en,
   input  logic                               in_valid,
   input  logic signed [dgp_pkg::VEC_W-1:0]   in_x,
   input  logic signed [dgp_pkg::VEC_W-1:0]   in_y,
   input  logic [31:0]                        in_ang,
   input  logic [SIDE_W-1:0]                  in_side,
   output logic                               out_valid,
   output logic signed [dgp_pkg::VEC_W-1:0]   out_x,
   output logic [31:0]                        out_ang,
   output logic [SIDE_W-1:0]                  out_side
);
   import dgp_pkg::*;

   logic [STAGES-1:0]        v_ff;
   logic signed [VEC_W-1:0]  x_ff [STAGES];
   logic signed [VEC_W-1:0]  y_ff [STAGES];
   logic [31:0]              a_ff [STAGES];
   logic [SIDE_W-1:0]        s_ff [STAGES];

   for (genvar g = 0; g < STAGES; g++) begin : g_stage
      logic signed [VEC_W-1:0] xp, yp, x_in, y_in;
      logic [31:0]             ap, a_in;
      logic [SIDE_W-1:0]       sp;
      logic                    vp;
      if (g == 0) begin : g_first
         assign xp = in_x;
         assign yp = in_y;
         assign ap = in_ang;
         assign sp = in_side;
         assign vp = in_valid;
      end else begin : g_next
         assign xp = x_ff[g-1];
         assign yp = y_ff[g-1];
         assign ap = a_ff[g-1];
         assign sp = s_ff[g-1];
         assign vp = v_ff[g-1];
      end

      // rotate clockwise while y is not negative
      always_comb begin
         if (!yp[VEC_W-1]) begin
            x_in = xp + (yp >>> g);
            y_in = yp - (xp >>> g);
            a_in = ap + ATAN_TAB[g];
         end else begin
            x_in = xp - (yp >>> g);
            y_in = yp + (xp >>> g);
            a_in = ap - ATAN_TAB[g];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[g] <= 1'b0;
         end else if (en) begin
            v_ff[g] <= vp;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[g] <= x_in;
            y_ff[g] <= y_in;
            a_ff[g] <= a_in;
            s_ff[g] <= sp;
         end
      end
   end

   assign out_valid = v_ff[STAGES-1];
   assign out_x     = x_ff[STAGES-1];
   assign out_ang   = a_ff[STAGES-1];
   assign out_side  = s_ff[STAGES-1];

endmodule

// ===== sv/dgp_rot_cordic.sv =====
// rotation cordic pipeline giving the cosine in q30, with sideband
module dgp_rot_cordic #(
   parameter int STAGES = dgp_pkg::CORDIC_STAGES_DEFAULT,
   parameter int SIDE_W = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               en,
   input  logic                               in_valid,
   input  logic signed [dgp_pkg::ROT_W-1:0]   in_z,
   input  logic [SIDE_W-1:0]                  in_side,
   output logic                               out_valid,
   output logic signed [dgp_pkg::ROT_W-1:0]   out_x,
   output logic [SIDE_W-1:0]                  out_side
);
   import dgp_pkg::*;

   logic [STAGES-1:0]        v_ff;
   logic signed [ROT_W-1:0]  x_ff [STAGES];
   logic signed [ROT_W-1:0]  y_ff [STAGES];
   logic signed [ROT_W-1:0]  z_ff [STAGES];
   logic [SIDE_W-1:0]        s_ff [STAGES];

   for (genvar g = 0; g < STAGES; g++) begin : g_stage
      logic signed [ROT_W-1:0] xp, yp, zp, x_in, y_in, z_in, at;
      logic [SIDE_W-1:0]       sp;
      logic                    vp;
      if (g == 0) begin : g_first
         assign xp = INV_GAIN_Q30;
         assign yp = '0;
         assign zp = in_z;
         assign sp = in_side;
         assign vp = in_valid;
      end else begin : g_next
         assign xp = x_ff[g-1];
         assign yp = y_ff[g-1];
         assign zp = z_ff[g-1];
         assign sp = s_ff[g-1];
         assign vp = v_ff[g-1];
      end
      assign at = $signed({1'b0, ATAN_TAB[g]});

      always_comb begin
         if (!zp[ROT_W-1]) begin
            x_in = xp - (yp >>> g);
            y_in = yp + (xp >>> g);
            z_in = zp - at;
         end else begin
            x_in = xp + (yp >>> g);
            y_in = yp - (xp >>> g);
            z_in = zp + at;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[g] <= 1'b0;
         end else if (en) begin
            v_ff[g] <= vp;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[g] <= x_in;
            y_ff[g] <= y_in;
            z_ff[g] <= z_in;
            s_ff[g] <= sp;
         end
      end
   end

   assign out_valid = v_ff[STAGES-1];
   assign out_x     = x_ff[STAGES-1];
   assign out_side  = s_ff[STAGES-1];

endmodule
